[src/bpti_pkg.sv]
// Package: shared types, constants and request codes for the B+ tree internal node.
`timescale 1ns / 1ps
package bpti_pkg;
	localparam int MAX_KEYS_DEF       = 32;
	localparam int CHILD_REF_BITS_DEF = 16;
	localparam int KEY_W              = 32;
	localparam int REQ_W              = 2;
	localparam int STATUS_W           = 2;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_FIND   = 2'd1,
		REQ_SPLIT  = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KSCAN,
		S_KSHIFT,
		S_KPUT,
		S_CPREP,
		S_CSHIFT,
		S_CPUT,
		S_FSCAN,
		S_FREAD,
		S_SEP,
		S_SPLIT,
		S_OUT
	} state_t;
endpackage

[src/bpti_if.sv]
// Interfaces: valid/ready channels for request and result items.
`timescale 1ns / 1ps
interface bpti_req_if
	import bpti_pkg::*;
#(parameter int CHILD_REF_BITS = CHILD_REF_BITS_DEF);
	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [KEY_W-1:0]   key;
	logic [CHILD_REF_BITS-1:0] left_child;
	logic                      left_valid;
	logic [CHILD_REF_BITS-1:0] right_child;
	logic                      right_valid;
	modport source (output valid, req_type, key, left_child, left_valid, right_child,
		right_valid, input ready);
	modport sink (input valid, req_type, key, left_child, left_valid, right_child,
		right_valid, output ready);
endinterface

interface bpti_res_if
	import bpti_pkg::*;
#(parameter int CHILD_REF_BITS = CHILD_REF_BITS_DEF);
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [CHILD_REF_BITS-1:0] found_child;
	logic                      found_valid;
	logic signed [KEY_W-1:0]   separator_key;
	logic signed [KEY_W-1:0]   moved_key;
	logic                      moved_key_valid;
	logic [CHILD_REF_BITS-1:0] moved_child;
	logic                      last;
	modport source (output valid, status, found_child, found_valid, separator_key,
		moved_key, moved_key_valid, moved_child, last, input ready);
	modport sink (input valid, status, found_child, found_valid, separator_key,
		moved_key, moved_key_valid, moved_child, last, output ready);
endinterface

[src/bpti_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bpti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/bplus_tree_internal_node.sv]
// Top level: B+ tree internal node held in key and child RAMs with a sequencer.
`timescale 1ns / 1ps
// One internal node of a B+ tree: sorted signed keys in a key RAM and child
// references in a child RAM, both with a registered read. Requests are taken
// one at a time; the request port is ready only while the sequencer is idle.
// Every RAM step is a read, then a compare or a write back. An insert runs a
// lower-bound scan and a key shift, then a shift and a place for each child; a
// find scans the keys and then reads the child; a split reads the separator and
// then emits n - n/2 result transfers for n stored keys; a no-op or a request on
// a full or empty node goes straight to its result. A result that waits in the
// output register stalls the sequencer and with it the request port. A full node
// reports status 1 and drops the insert, a child that does not fit is dropped
// with status 1, and a missing child shows as found_valid low or a zero moved
// child.
module bplus_tree_internal_node
	import bpti_pkg::*;
#(
	parameter int MAX_KEYS       = MAX_KEYS_DEF,
	parameter int CHILD_REF_BITS = CHILD_REF_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	bpti_req_if.sink   req,
	bpti_res_if.source res
);
	localparam int SLOTS = MAX_KEYS + 1;
	localparam int KA_W  = $clog2(MAX_KEYS);
	localparam int CA_W  = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CW    = CHILD_REF_BITS;

	state_t state_q, state_d;
	logic [CNT_W-1:0] kcnt_q, ccnt_q, i_q, pos_q, lim_q, items_q;
	logic signed [KEY_W-1:0] key_q, sep_q;
	logic [CW-1:0] lch_q, rch_q, fc_q;
	logic lv_q, rv_q, rdpend_q, right_q, fv_q;
	status_t st_q, st_acc;

	// RAM ports
	logic k_we, c_we;
	logic [KA_W-1:0] k_wa, k_ra;
	logic [CA_W-1:0] c_wa, c_ra;
	logic [KEY_W-1:0] k_wd, k_rd;
	logic [CW-1:0] c_wd, c_rd;

	bpti_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
	bpti_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_child_ram (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

	// output register
	logic ov_q;
	status_t o_st_q;
	logic [CW-1:0] o_fc_q, o_mc_q;
	logic o_fv_q, o_mv_q, o_last_q;
	logic signed [KEY_W-1:0] o_sep_q, o_mk_q;

	logic acc, out_free, load_out;
	assign acc       = req.valid && req.ready;
	assign out_free  = !ov_q || res.ready;
	assign req.ready = (state_q == S_IDLE);

	assign res.valid           = ov_q;
	assign res.status          = o_st_q;
	assign res.found_child     = o_fc_q;
	assign res.found_valid     = o_fv_q;
	assign res.separator_key   = o_sep_q;
	assign res.moved_key       = o_mk_q;
	assign res.moved_key_valid = o_mv_q;
	assign res.moved_child     = o_mc_q;
	assign res.last            = o_last_q;

	// scan compares, child placement and split addressing
	logic key_ge, key_lt, kscan_end, fscan_end, split_last, cwant_c;
	logic [CNT_W-1:0] mid_c, ci_c, ctgt_c, cpos_c;
	assign key_ge     = !($signed(k_rd) < key_q);
	assign key_lt     = key_q < $signed(k_rd);
	assign kscan_end  = rdpend_q ? key_ge : (i_q == kcnt_q);
	assign fscan_end  = rdpend_q ? key_lt : (i_q == kcnt_q);
	assign mid_c      = kcnt_q >> 1;
	assign ci_c       = mid_c + CNT_W'(1) + i_q;
	assign split_last = (i_q + CNT_W'(1) == items_q);
	assign ctgt_c     = right_q ? pos_q + CNT_W'(1) : pos_q;
	assign cpos_c     = (ctgt_c > ccnt_q) ? ccnt_q : ctgt_c;
	assign cwant_c    = right_q ? rv_q : lv_q;
	assign load_out   = out_free &&
		((state_q == S_OUT) || (state_q == S_SPLIT && rdpend_q));

	// status known at request transfer
	always_comb begin
		case (req_t'(req.req_type))
			REQ_INSERT: st_acc = (kcnt_q >= CNT_W'(MAX_KEYS)) ? ST_FULL : ST_OK;
			REQ_FIND, REQ_SPLIT: st_acc = (kcnt_q == '0) ? ST_EMPTY : ST_OK;
			default: st_acc = ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req_t'(req.req_type))
						REQ_INSERT: state_d = (kcnt_q >= CNT_W'(MAX_KEYS)) ? S_OUT : S_KSCAN;
						REQ_FIND:   state_d = (kcnt_q == '0) ? S_OUT : S_FSCAN;
						REQ_SPLIT:  state_d = (kcnt_q == '0) ? S_OUT : S_SEP;
						default:    state_d = S_OUT;
					endcase
				end
			end
			S_KSCAN:  if (kscan_end) state_d = S_KSHIFT;
			S_KSHIFT: if (!rdpend_q && i_q == pos_q) state_d = S_KPUT;
			S_KPUT:   state_d = S_CPREP;
			S_CPREP: begin
				if (cwant_c && ccnt_q < CNT_W'(SLOTS)) state_d = S_CSHIFT;
				else if (right_q) state_d = S_OUT;
			end
			S_CSHIFT: if (!rdpend_q && i_q == lim_q) state_d = S_CPUT;
			S_CPUT:   state_d = right_q ? S_OUT : S_CPREP;
			S_FSCAN:  if (fscan_end) state_d = (i_q < ccnt_q) ? S_FREAD : S_OUT;
			S_FREAD:  if (rdpend_q) state_d = S_OUT;
			S_SEP:    if (rdpend_q) state_d = S_SPLIT;
			S_SPLIT:  if (rdpend_q && out_free && split_last) state_d = S_IDLE;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// RAM addressing and write data
	always_comb begin
		k_we = 1'b0;
		k_wa = KA_W'(i_q);
		k_wd = k_rd;
		k_ra = KA_W'(i_q);
		c_we = 1'b0;
		c_wa = CA_W'(i_q);
		c_wd = c_rd;
		c_ra = CA_W'(i_q);
		case (state_q)
			S_KSHIFT: begin
				// read entry i-1, then write it to entry i
				k_ra = KA_W'(i_q - CNT_W'(1));
				k_we = rdpend_q;
			end
			S_KPUT: begin
				k_we = 1'b1;
				k_wa = KA_W'(pos_q);
				k_wd = key_q;
			end
			S_CSHIFT: begin
				c_ra = CA_W'(i_q - CNT_W'(1));
				c_we = rdpend_q;
			end
			S_CPUT: begin
				c_we = 1'b1;
				c_wa = CA_W'(lim_q);
				c_wd = right_q ? rch_q : lch_q;
			end
			S_SEP: k_ra = KA_W'(mid_c);
			S_SPLIT: begin
				k_ra = KA_W'(ci_c);
				c_ra = CA_W'(ci_c);
			end
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kcnt_q   <= '0;
			ccnt_q   <= '0;
			i_q      <= '0;
			pos_q    <= '0;
			lim_q    <= '0;
			items_q  <= '0;
			key_q    <= '0;
			sep_q    <= '0;
			lch_q    <= '0;
			rch_q    <= '0;
			fc_q     <= '0;
			lv_q     <= 1'b0;
			rv_q     <= 1'b0;
			rdpend_q <= 1'b0;
			right_q  <= 1'b0;
			fv_q     <= 1'b0;
			st_q     <= ST_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						key_q <= req.key;
						lch_q <= req.left_child;
						rch_q <= req.right_child;
						lv_q <= req.left_valid;
						rv_q <= req.right_valid;
						i_q <= '0;
						rdpend_q <= 1'b0;
						right_q <= 1'b0;
						fc_q <= '0;
						fv_q <= 1'b0;
						st_q <= st_acc;
						items_q <= kcnt_q - mid_c;
					end
				end
				S_KSCAN: begin
					// stop at the first stored key not below the request key
					if (kscan_end) begin
						pos_q <= i_q;
						i_q <= kcnt_q;
						rdpend_q <= 1'b0;
					end else if (rdpend_q) begin
						i_q <= i_q + CNT_W'(1);
						rdpend_q <= 1'b0;
					end else begin
						rdpend_q <= 1'b1;
					end
				end
				S_KSHIFT, S_CSHIFT: begin
					if (rdpend_q) begin
						i_q <= i_q - CNT_W'(1);
						rdpend_q <= 1'b0;
					end else if (i_q != ((state_q == S_KSHIFT) ? pos_q : lim_q)) begin
						rdpend_q <= 1'b1;
					end
				end
				S_KPUT: kcnt_q <= kcnt_q + CNT_W'(1);
				S_CPREP: begin
					// place the child if wanted and room is left, else drop it
					if (cwant_c && ccnt_q < CNT_W'(SLOTS)) begin
						i_q <= ccnt_q;
						lim_q <= cpos_c;
						rdpend_q <= 1'b0;
					end else begin
						if (cwant_c) st_q <= ST_FULL;
						right_q <= 1'b1;
					end
				end
				S_CPUT: begin
					ccnt_q <= ccnt_q + CNT_W'(1);
					right_q <= 1'b1;
				end
				S_FSCAN: begin
					// stop at the first stored key above the search key
					if (fscan_end) begin
						rdpend_q <= 1'b0;
					end else if (rdpend_q) begin
						i_q <= i_q + CNT_W'(1);
						rdpend_q <= 1'b0;
					end else begin
						rdpend_q <= 1'b1;
					end
				end
				S_FREAD: begin
					if (rdpend_q) begin
						fc_q <= c_rd;
						fv_q <= 1'b1;
						rdpend_q <= 1'b0;
					end else begin
						rdpend_q <= 1'b1;
					end
				end
				S_SEP: begin
					if (rdpend_q) begin
						sep_q <= $signed(k_rd);
						i_q <= '0;
						rdpend_q <= 1'b0;
					end else begin
						rdpend_q <= 1'b1;
					end
				end
				S_SPLIT: begin
					// advance one moved entry per result transfer, trim on the last
					if (!rdpend_q) begin
						rdpend_q <= 1'b1;
					end else if (out_free) begin
						rdpend_q <= 1'b0;
						if (split_last) begin
							kcnt_q <= mid_c;
							if (ccnt_q > mid_c + CNT_W'(1)) ccnt_q <= mid_c + CNT_W'(1);
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register: load a result or drop the one just transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q     <= 1'b0;
			o_st_q   <= ST_OK;
			o_fc_q   <= '0;
			o_fv_q   <= 1'b0;
			o_sep_q  <= '0;
			o_mk_q   <= '0;
			o_mv_q   <= 1'b0;
			o_mc_q   <= '0;
			o_last_q <= 1'b0;
		end else begin
			ov_q <= load_out || (ov_q && !res.ready);
			if (load_out) begin
				if (state_q == S_SPLIT) begin
					o_st_q   <= ST_OK;
					o_fc_q   <= '0;
					o_fv_q   <= 1'b0;
					o_sep_q  <= sep_q;
					o_mk_q   <= (ci_c < kcnt_q) ? $signed(k_rd) : '0;
					o_mv_q   <= (ci_c < kcnt_q);
					o_mc_q   <= (ci_c < ccnt_q) ? c_rd : '0;
					o_last_q <= split_last;
				end else begin
					o_st_q   <= st_q;
					o_fc_q   <= fc_q;
					o_fv_q   <= fv_q;
					o_sep_q  <= '0;
					o_mk_q   <= '0;
					o_mv_q   <= 1'b0;
					o_mc_q   <= '0;
					o_last_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		kcnt_q <= CNT_W'(MAX_KEYS)) else $error("key count overflow");
	a_ccnt: assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q <= CNT_W'(SLOTS)) else $error("child count overflow");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE) else $error("request taken without work");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !res.ready |=> ov_q) else $error("result dropped while stalled");
`endif
endmodule
